[sv/weighted_pixel_blend_core_macros.svh]
`ifndef WEIGHTED_PIXEL_BLEND_CORE_MACROS_SVH
`define WEIGHTED_PIXEL_BLEND_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define WPB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define WPB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

[sv/wpb_pkg.sv]
`timescale 1ns / 1ps

package wpb_pkg;

	// pixel_format codes; code 3 is treated as 32-bit RGBX
	localparam logic [1:0] FMT_RGB555 = 2'd0;
	localparam logic [1:0] FMT_RGB888 = 2'd1;
	localparam logic [1:0] FMT_RGBX   = 2'd2;
	localparam logic [1:0] FMT_RESET  = FMT_RGB888;

	localparam int unsigned ACC_W  = 40;
	localparam int unsigned FRAC_W = 12;
	localparam int unsigned PROD_W = 25;

	localparam logic [7:0] MAX_CH5 = 8'h1f;
	localparam logic [7:0] MAX_CH8 = 8'hff;

	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic signed [15:0] weight;
		logic               last;
		logic [1:0]         fmt;
	} item_t;

	// floor Q.12 to integer, clamp to [0, channel max]
	function automatic logic [7:0] finish_channel(input logic [ACC_W-1:0] sum,
			input logic narrow);
		logic [ACC_W-FRAC_W-1:0] v;
		logic [7:0]              maxv;
		maxv = narrow ? MAX_CH5 : MAX_CH8;
		v    = sum[ACC_W-1:FRAC_W];
		if (sum[ACC_W-1]) begin
			return 8'd0;
		end else if (v > {{(ACC_W-FRAC_W-8){1'b0}}, maxv}) begin
			return maxv;
		end else begin
			return v[7:0];
		end
	endfunction

	function automatic logic [31:0] pack_pixel(input logic [1:0] fmt,
			input logic [ACC_W-1:0] rs, input logic [ACC_W-1:0] gs,
			input logic [ACC_W-1:0] bs);
		logic       narrow;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [31:0] px;
		narrow = (fmt == FMT_RGB555);
		r = finish_channel(rs, narrow);
		g = finish_channel(gs, narrow);
		b = finish_channel(bs, narrow);
		unique case (fmt)
			FMT_RGB555: px = {16'd0, r[4:0], g[4:0], 1'b0, b[4:0]};
			FMT_RGB888: px = {8'd0, r, g, b};
			default:    px = {r, g, b, MAX_CH8};
		endcase
		return px;
	endfunction

endpackage

[sv/wpb_pix_if.sv]
`timescale 1ns / 1ps

interface wpb_pix_if;
	logic               valid;
	logic               ready;
	logic [31:0]        pixel_word;
	logic signed [15:0] weight;
	logic               last_item;

	modport source(output valid, output pixel_word, output weight, output last_item,
		input ready);
	modport sink(input valid, input pixel_word, input weight, input last_item,
		output ready);
endinterface

[sv/wpb_res_if.sv]
`timescale 1ns / 1ps

interface wpb_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] blended_pixel;

	modport source(output valid, output blended_pixel, input ready);
	modport sink(input valid, input blended_pixel, output ready);
endinterface

[sv/wpb_unpack.sv]
`timescale 1ns / 1ps

// input register: takes a request and splits the pixel into channels
module wpb_unpack (
	input  logic                clk,
	input  logic                arst_n,
	wpb_pix_if.sink             pix,
	input  logic [1:0]          fmt,
	output wpb_pkg::item_t      item,
	output logic                item_valid,
	input  logic                item_ready
);

	logic           valid_s1;
	wpb_pkg::item_t item_s1;
	logic [7:0]     red;
	logic [7:0]     green;
	logic [7:0]     blue;

	always_comb begin
		unique case (fmt)
			wpb_pkg::FMT_RGB555: begin
				red   = {3'd0, pix.pixel_word[15:11]};
				green = {3'd0, pix.pixel_word[10:6]};
				blue  = {3'd0, pix.pixel_word[4:0]};
			end
			wpb_pkg::FMT_RGB888: begin
				red   = pix.pixel_word[23:16];
				green = pix.pixel_word[15:8];
				blue  = pix.pixel_word[7:0];
			end
			default: begin
				red   = pix.pixel_word[31:24];
				green = pix.pixel_word[23:16];
				blue  = pix.pixel_word[15:8];
			end
		endcase
	end

	assign pix.ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			item_s1.red    <= red;
			item_s1.green  <= green;
			item_s1.blue   <= blue;
			item_s1.weight <= pix.weight;
			item_s1.last   <= pix.last_item;
			item_s1.fmt    <= fmt;
		end
	end

	assign item       = item_s1;
	assign item_valid = valid_s1;

endmodule

[sv/wpb_mac.sv]
`timescale 1ns / 1ps

`include "weighted_pixel_blend_core_macros.svh"

// product register, three accumulators and the result register
module wpb_mac (
	input  logic           clk,
	input  logic           arst_n,
	input  wpb_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_ready,
	wpb_res_if.source      res
);

	logic                              valid_s2;
	logic signed [wpb_pkg::PROD_W-1:0] prod_r_s2;
	logic signed [wpb_pkg::PROD_W-1:0] prod_g_s2;
	logic signed [wpb_pkg::PROD_W-1:0] prod_b_s2;
	logic                              last_s2;
	logic [1:0]                        fmt_s2;

	logic [wpb_pkg::ACC_W-1:0] red_sum_q;
	logic [wpb_pkg::ACC_W-1:0] green_sum_q;
	logic [wpb_pkg::ACC_W-1:0] blue_sum_q;
	logic [wpb_pkg::ACC_W-1:0] red_next;
	logic [wpb_pkg::ACC_W-1:0] green_next;
	logic [wpb_pkg::ACC_W-1:0] blue_next;

	logic        out_valid_q;
	logic [31:0] pixel_q;
	logic        acc_take;
	logic        s2_load;

	// only a run end has to wait for the result register
	assign acc_take   = valid_s2 && !(last_s2 && out_valid_q && !res.ready);
	assign s2_load    = !valid_s2 || acc_take;
	assign item_ready = s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && item_valid) begin
			prod_r_s2 <= item.weight * $signed({1'b0, item.red});
			prod_g_s2 <= item.weight * $signed({1'b0, item.green});
			prod_b_s2 <= item.weight * $signed({1'b0, item.blue});
			last_s2   <= item.last;
			fmt_s2    <= item.fmt;
		end
	end

	assign red_next   = red_sum_q
		+ {{(wpb_pkg::ACC_W-wpb_pkg::PROD_W){prod_r_s2[wpb_pkg::PROD_W-1]}}, prod_r_s2};
	assign green_next = green_sum_q
		+ {{(wpb_pkg::ACC_W-wpb_pkg::PROD_W){prod_g_s2[wpb_pkg::PROD_W-1]}}, prod_g_s2};
	assign blue_next  = blue_sum_q
		+ {{(wpb_pkg::ACC_W-wpb_pkg::PROD_W){prod_b_s2[wpb_pkg::PROD_W-1]}}, prod_b_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_sum_q   <= '0;
			green_sum_q <= '0;
			blue_sum_q  <= '0;
		end else if (acc_take) begin
			if (last_s2) begin
				red_sum_q   <= '0;
				green_sum_q <= '0;
				blue_sum_q  <= '0;
			end else begin
				red_sum_q   <= red_next;
				green_sum_q <= green_next;
				blue_sum_q  <= blue_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_take && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_take && last_s2) begin
			pixel_q <= wpb_pkg::pack_pixel(fmt_s2, red_next, green_next, blue_next);
		end
	end

	assign res.valid         = out_valid_q;
	assign res.blended_pixel = pixel_q;

	`WPB_ASSERT_NEXT(a_sums_cleared, acc_take && last_s2, red_sum_q == '0 && green_sum_q == '0 && blue_sum_q == '0)
	`WPB_ASSERT_SAME(a_result_from_run_end, $rose(out_valid_q), $past(acc_take && last_s2))
	`WPB_ASSERT_NEXT(a_rgb555_unused_zero, acc_take && last_s2 && fmt_s2 == wpb_pkg::FMT_RGB555, pixel_q[31:16] == 16'd0 && pixel_q[5] == 1'b0)
	`WPB_ASSERT_NEXT(a_product_held, valid_s2 && !acc_take, valid_s2 && $stable(prod_r_s2) && $stable(last_s2))

endmodule

[sv/weighted_pixel_blend_core.sv]
`timescale 1ns / 1ps

// Weighted pixel blend core.
// pix carries one source pixel a request (pixel_word, signed Q4.12 weight,
// last_item); res carries one packed blended pixel per run. Both are
// valid/ready channels, a request moves when valid and ready are high.
// Each channel of every pixel is multiplied by its weight and summed into
// 40-bit accumulators; the request with last_item set closes the run: sums
// are floored, clamped to [0, channel maximum], packed, and cleared.
// pixel_format (APB register at address 0, reset 1) selects 16-bit 5:5:5,
// 24-bit RGB or 32-bit RGBX (low byte forced to 0xff); change it only idle.
// Throughput: one pixel per cycle unless a closing pixel waits on a held
// result, set by the single multiply stage and the accumulator loop (one
// 40-bit add a cycle). The closing request's result passes from the input
// register through the product register and then the result register.
// Reset clears the pipeline and result valid flags and the accumulators.
// When res stalls, pixels that do not close a run keep flowing into the
// accumulators; a closing pixel waits until the held result is taken, and
// pix.ready falls only once that wait has backed up the input register.
module weighted_pixel_blend_core (
	input  logic        clk,
	input  logic        arst_n,
	wpb_pix_if.sink     pix,
	wpb_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]     fmt_q;
	wpb_pkg::item_t item;
	logic           item_valid;
	logic           item_ready;
	logic           cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= wpb_pkg::FMT_RESET;
		end else if (cfg_write && paddr == wpb_pkg::REG_PIXEL_FORMAT) begin
			fmt_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr == wpb_pkg::REG_PIXEL_FORMAT) ? {30'd0, fmt_q} : 32'd0;

	wpb_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.fmt        (fmt_q),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready)
	);

	wpb_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.res        (res)
	);

endmodule
